@@ rtl/hpct_pkg.sv @@
`default_nettype none
package hpct_pkg;

    localparam int HIT_CAPACITY = 1024;
    localparam int IDX_W        = $clog2(HIT_CAPACITY);
    localparam int CNT_W        = $clog2(HIT_CAPACITY + 1);
    localparam int COORD_W      = 16;
    localparam int DIST_W       = 16;
    localparam int WEIGHT_W     = 16;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 2;

    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUERY    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_DIST = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [DIST_W-1:0] RANGE_LO_RST = 16'd200;
    localparam logic [DIST_W-1:0] RANGE_HI_RST = 16'd8000;
    localparam logic [DIST_W-1:0] HIT_DIST_RST = 16'd200;

    typedef struct packed {
        logic load;
        logic setup;
        logic scan;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic skip_scan;
        logic hit;
        logic scan_end;
    } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/hpct_ctrl.sv @@
`default_nettype none
module hpct_ctrl
    import hpct_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    output logic          done,
    output dp_cmd_t       dp_cmd,
    input  wire dp_stat_t dp_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        dp_cmd.load   = 1'b0;
        dp_cmd.setup  = 1'b0;
        dp_cmd.scan   = 1'b0;
        dp_cmd.update = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                dp_cmd.setup = 1'b1;
                state_next   = dp_stat.skip_scan ? S_UPDATE : S_SCAN;
            end
            S_SCAN:
            begin
                dp_cmd.scan = 1'b1;
                if (dp_stat.hit || dp_stat.scan_end)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                dp_cmd.update = 1'b1;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

@@ rtl/hpct_dp.sv @@
`default_nettype none
module hpct_dp
    import hpct_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dp_cmd_t                    dp_cmd,
    output dp_stat_t                        dp_stat,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [DIST_W-1:0]          cfg_data,
    input  wire logic                       cmd,
    input  wire logic signed [COORD_W-1:0]  pos_x,
    input  wire logic signed [COORD_W-1:0]  pos_y,
    input  wire logic [DIST_W-1:0]          range_mm,
    input  wire logic [DIST_W-1:0]          query_dist_mm,
    output logic [STATUS_W-1:0]             status,
    output logic                            occupied,
    output logic [IDX_W-1:0]                entry_index,
    output logic [WEIGHT_W-1:0]             entry_weight,
    output logic [CNT_W-1:0]                stored_count
);

    localparam logic [CNT_W-1:0]    CAP_CNT = CNT_W'(HIT_CAPACITY);
    localparam logic [WEIGHT_W-1:0] W_MAX   = '1;
    localparam logic [WEIGHT_W-1:0] W_ONE   = WEIGHT_W'(1);

    logic signed [COORD_W-1:0] mem_x [HIT_CAPACITY];
    logic signed [COORD_W-1:0] mem_y [HIT_CAPACITY];
    logic [WEIGHT_W-1:0]       mem_w [HIT_CAPACITY];

    logic [DIST_W-1:0]         range_lo_reg;
    logic [DIST_W-1:0]         range_hi_reg;
    logic [DIST_W-1:0]         hit_dist_reg;

    logic                      cmd_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic [DIST_W-1:0]         range_reg;
    logic [DIST_W-1:0]         qdist_reg;
    logic [2*DIST_W-1:0]       rsq_reg;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          addr_reg;
    logic                      issue;

    logic                      s1_valid_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    logic signed [COORD_W-1:0] s1_x_reg;
    logic signed [COORD_W-1:0] s1_y_reg;
    logic [WEIGHT_W-1:0]       s1_w_reg;

    logic                      s2_valid_reg;
    logic [IDX_W-1:0]          s2_idx_reg;
    logic signed [COORD_W:0]   s2_dx_reg;
    logic signed [COORD_W:0]   s2_dy_reg;
    logic [WEIGHT_W-1:0]       s2_w_reg;

    logic                      s3_valid_reg;
    logic [IDX_W-1:0]          s3_idx_reg;
    logic [2*COORD_W-1:0]      s3_dx2_reg;
    logic [2*COORD_W-1:0]      s3_dy2_reg;
    logic [WEIGHT_W-1:0]       s3_w_reg;

    logic                      s4_valid_reg;
    logic                      s4_hit_reg;
    logic [IDX_W-1:0]          s4_idx_reg;
    logic [WEIGHT_W-1:0]       s4_w_reg;

    logic                      found_reg;
    logic [IDX_W-1:0]          match_idx_reg;
    logic [WEIGHT_W-1:0]       match_w_reg;

    logic [STATUS_W-1:0]       status_reg;
    logic                      occupied_reg;
    logic [IDX_W-1:0]          index_reg;
    logic [WEIGHT_W-1:0]       weight_reg;
    logic [CNT_W-1:0]          pcount_reg;

    logic [STATUS_W-1:0]       status_next;
    logic                      occupied_next;
    logic [IDX_W-1:0]          index_next;
    logic [WEIGHT_W-1:0]       weight_next;

    logic                      in_window;
    logic [DIST_W-1:0]         radius;
    logic signed [2*COORD_W+1:0] dx_sq;
    logic signed [2*COORD_W+1:0] dy_sq;
    logic [2*COORD_W:0]        dist_sq;
    logic                      s3_hit;
    logic [WEIGHT_W-1:0]       w_inc;
    logic                      wr_merge;
    logic                      wr_append;

    assign in_window = (range_reg > range_lo_reg) && (range_reg <= range_hi_reg);
    assign radius    = (cmd_reg == CMD_QUERY) ? qdist_reg : hit_dist_reg;
    assign issue     = dp_cmd.scan && (addr_reg < count_reg) && !s4_hit_reg;

    assign dx_sq   = s2_dx_reg * s2_dx_reg;
    assign dy_sq   = s2_dy_reg * s2_dy_reg;
    assign dist_sq = {1'b0, s3_dx2_reg} + {1'b0, s3_dy2_reg};
    assign s3_hit  = s3_valid_reg && (dist_sq < {1'b0, rsq_reg})
                     && ((s3_w_reg != '0) || (cmd_reg == CMD_INSERT));

    assign dp_stat.skip_scan = (cmd_reg == CMD_INSERT) && !in_window;
    assign dp_stat.hit       = s4_hit_reg;
    assign dp_stat.scan_end  = (addr_reg >= count_reg) && !s1_valid_reg && !s2_valid_reg
                               && !s3_valid_reg && !s4_valid_reg;

    assign w_inc = (match_w_reg == W_MAX) ? match_w_reg : match_w_reg + W_ONE;

    always_comb
    begin
        status_next   = ST_DROPPED;
        occupied_next = 1'b0;
        index_next    = '0;
        weight_next   = '0;
        count_next    = count_reg;
        wr_merge      = 1'b0;
        wr_append     = 1'b0;
        if (cmd_reg == CMD_QUERY)
        begin
            status_next   = ST_QUERY;
            occupied_next = found_reg;
        end
        else if (!in_window)
        begin
            status_next = ST_IGNORED;
        end
        else if (found_reg)
        begin
            status_next = ST_MERGED;
            index_next  = match_idx_reg;
            weight_next = w_inc;
            wr_merge    = dp_cmd.update;
        end
        else if (count_reg < CAP_CNT)
        begin
            status_next = ST_APPENDED;
            index_next  = count_reg[IDX_W-1:0];
            weight_next = W_ONE;
            count_next  = count_reg + CNT_W'(1);
            wr_append   = dp_cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_append)
        begin
            mem_x[count_reg[IDX_W-1:0]] <= x_reg;
            mem_y[count_reg[IDX_W-1:0]] <= y_reg;
            mem_w[count_reg[IDX_W-1:0]] <= W_ONE;
        end
        if (wr_merge)
        begin
            mem_w[match_idx_reg] <= w_inc;
        end
        s1_x_reg <= mem_x[addr_reg[IDX_W-1:0]];
        s1_y_reg <= mem_y[addr_reg[IDX_W-1:0]];
        s1_w_reg <= mem_w[addr_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg   <= cmd;
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            range_reg <= range_mm;
            qdist_reg <= query_dist_mm;
        end
        if (dp_cmd.setup)
        begin
            rsq_reg <= radius * radius;
        end
        s1_idx_reg <= addr_reg[IDX_W-1:0];
        s2_idx_reg <= s1_idx_reg;
        s2_dx_reg  <= {s1_x_reg[COORD_W-1], s1_x_reg} - {x_reg[COORD_W-1], x_reg};
        s2_dy_reg  <= {s1_y_reg[COORD_W-1], s1_y_reg} - {y_reg[COORD_W-1], y_reg};
        s2_w_reg   <= s1_w_reg;
        s3_idx_reg <= s2_idx_reg;
        s3_dx2_reg <= dx_sq[2*COORD_W-1:0];
        s3_dy2_reg <= dy_sq[2*COORD_W-1:0];
        s3_w_reg   <= s2_w_reg;
        s4_idx_reg <= s3_idx_reg;
        s4_w_reg   <= s3_w_reg;
        if (dp_cmd.scan && s4_hit_reg && !found_reg)
        begin
            match_idx_reg <= s4_idx_reg;
            match_w_reg   <= s4_w_reg;
        end
        if (dp_cmd.update)
        begin
            status_reg   <= status_next;
            occupied_reg <= occupied_next;
            index_reg    <= index_next;
            weight_reg   <= weight_next;
            pcount_reg   <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_lo_reg <= RANGE_LO_RST;
            range_hi_reg <= RANGE_HI_RST;
            hit_dist_reg <= HIT_DIST_RST;
            count_reg     <= '0;
            addr_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s4_hit_reg    <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RANGE_LO: range_lo_reg <= cfg_data;
                    CFG_RANGE_HI: range_hi_reg <= cfg_data;
                    CFG_HIT_DIST: hit_dist_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (dp_cmd.setup)
            begin
                addr_reg     <= '0;
                s1_valid_reg <= 1'b0;
                s2_valid_reg <= 1'b0;
                s3_valid_reg <= 1'b0;
                s4_valid_reg <= 1'b0;
                s4_hit_reg   <= 1'b0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    addr_reg <= addr_reg + CNT_W'(1);
                end
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s4_hit_reg   <= s3_hit;
                if (dp_cmd.scan && s4_hit_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (dp_cmd.update)
            begin
                count_reg <= count_next;
            end
        end
    end

    assign status       = status_reg;
    assign occupied     = occupied_reg;
    assign entry_index  = index_reg;
    assign entry_weight = weight_reg;
    assign stored_count = pcount_reg;

endmodule
`default_nettype wire

@@ rtl/hit_point_cluster_table_top.sv @@
`default_nettype none
// Hit point cluster table: clusters 2-D obstacle hits (mm) with a count weight.
// Request channel: start is taken when busy is low; cmd selects insert (0) or
// occupancy query (1) with pos_x, pos_y, range_mm, query_dist_mm.
// Result channel: done pulses for one cycle with status, occupied, entry_index,
// entry_weight and stored_count; results hold until the next done.
// The receiver cannot stall; each request returns exactly one result.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 min range, 1 max range,
// 2 merge radius) and cfg_data; ready only while idle, other indexes ignored.
// An insert outside the range window skips the scan; otherwise the table is
// scanned one slot per cycle through a 4-stage read/subtract/square/compare
// pipeline over the N stored slots (up to 1024), ending early on a match.
// One request at a time: busy stays high until done.
// Reset clears the point count and restores the range/radius registers;
// slot storage is not cleared, only slots below the count are read.
module hit_point_cluster_table_top
    import hpct_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       cmd,
    input  wire logic signed [COORD_W-1:0]  pos_x,
    input  wire logic signed [COORD_W-1:0]  pos_y,
    input  wire logic [DIST_W-1:0]          range_mm,
    input  wire logic [DIST_W-1:0]          query_dist_mm,
    output logic                            done,
    output logic [STATUS_W-1:0]             status,
    output logic                            occupied,
    output logic [IDX_W-1:0]                entry_index,
    output logic [WEIGHT_W-1:0]             entry_weight,
    output logic [CNT_W-1:0]                stored_count,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [DIST_W-1:0]          cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     busy_int;

    assign busy      = busy_int;
    assign cfg_ready = !busy_int;

    hpct_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy_int),
        .done    (done),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

    hpct_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .cfg_we        (cfg_valid && !busy_int),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .range_mm      (range_mm),
        .query_dist_mm (query_dist_mm),
        .status        (status),
        .occupied      (occupied),
        .entry_index   (entry_index),
        .entry_weight  (entry_weight),
        .stored_count  (stored_count)
    );

endmodule
`default_nettype wire

@@ rtl/hpct_chk.sv @@
`default_nettype none
module hpct_chk
    import hpct_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 done,
    input wire logic [STATUS_W-1:0]  status,
    input wire logic                 occupied,
    input wire logic [IDX_W-1:0]     entry_index,
    input wire logic [WEIGHT_W-1:0]  entry_weight
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but busy not raised");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && !$past(done))
        else $error("done while busy or longer than one cycle");

    a_occ_query: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_QUERY |-> !occupied)
        else $error("occupied set on a non-query result");

    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_QUERY || status == ST_IGNORED || status == ST_DROPPED)
        |-> entry_index == '0 && entry_weight == '0)
        else $error("slot fields set on a result without a slot");

    a_append_w: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_APPENDED |-> entry_weight == WEIGHT_W'(1))
        else $error("appended point without unit weight");

endmodule

bind hit_point_cluster_table_top hpct_chk u_hpct_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .occupied     (occupied),
    .entry_index  (entry_index),
    .entry_weight (entry_weight)
);
`default_nettype wire

@@ sim/hpct_checker.sv @@
`timescale 1ns / 100ps
module hpct_checker
    import hpct_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       cmd,
    input  logic signed [COORD_W-1:0]  pos_x,
    input  logic signed [COORD_W-1:0]  pos_y,
    input  logic [DIST_W-1:0]          range_mm,
    input  logic [DIST_W-1:0]          query_dist_mm,
    input  logic                       done,
    input  logic [STATUS_W-1:0]        status,
    input  logic                       occupied,
    input  logic [IDX_W-1:0]           entry_index,
    input  logic [WEIGHT_W-1:0]        entry_weight,
    input  logic [CNT_W-1:0]           stored_count,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DIST_W-1:0]          cfg_data,
    output int                         errors,
    output int                         pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                occupied;
        logic [IDX_W-1:0]    index;
        logic [WEIGHT_W-1:0] weight;
        logic [CNT_W-1:0]    count;
    } outcome_t;

    outcome_t outcome_q[$];

    logic signed [COORD_W-1:0] pt_x [HIT_CAPACITY];
    logic signed [COORD_W-1:0] pt_y [HIT_CAPACITY];
    logic [WEIGHT_W-1:0]       pt_w [HIT_CAPACITY];
    int                        n_points = 0;

    logic [DIST_W-1:0] range_lo   = RANGE_LO_RST;
    logic [DIST_W-1:0] range_hi   = RANGE_HI_RST;
    logic [DIST_W-1:0] merge_dist = HIT_DIST_RST;

    int mismatches  = 0;
    int outstanding = 0;

    assign errors  = mismatches;
    assign pending = outstanding;

    // squared distance test, exact in 64 bits
    function automatic bit is_near(input int slot,
                                   input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y,
                                   input logic [DIST_W-1:0] radius);
        longint dx;
        longint dy;
        longint rr;
        dx = longint'(pt_x[slot]) - longint'(x);
        dy = longint'(pt_y[slot]) - longint'(y);
        rr = longint'(radius);
        return (dx * dx + dy * dy) < (rr * rr);
    endfunction

    function automatic outcome_t cluster_request(input logic c,
                                                 input logic signed [COORD_W-1:0] x,
                                                 input logic signed [COORD_W-1:0] y,
                                                 input logic [DIST_W-1:0] rng,
                                                 input logic [DIST_W-1:0] qd);
        outcome_t o;
        int j;
        o = '0;
        if (c == CMD_QUERY)
        begin
            o.status = ST_QUERY;
            for (j = 0; j < n_points; j++)
            begin
                if (pt_w[j] != '0 && is_near(j, x, y, qd))
                begin
                    o.occupied = 1'b1;
                    break;
                end
            end
        end
        else if (rng > range_hi || rng <= range_lo)
        begin
            o.status = ST_IGNORED;
        end
        else
        begin
            for (j = 0; j < n_points; j++)
            begin
                if (is_near(j, x, y, merge_dist))
                    break;
            end
            if (j < n_points)
            begin
                if (pt_w[j] != '1)
                    pt_w[j] = pt_w[j] + 1'b1;
                o.status = ST_MERGED;
                o.index  = IDX_W'(j);
                o.weight = pt_w[j];
            end
            else if (n_points < HIT_CAPACITY)
            begin
                pt_x[n_points] = x;
                pt_y[n_points] = y;
                pt_w[n_points] = WEIGHT_W'(1);
                o.status = ST_APPENDED;
                o.index  = IDX_W'(n_points);
                o.weight = WEIGHT_W'(1);
                n_points++;
            end
            else
            begin
                o.status = ST_DROPPED;
            end
        end
        o.count = CNT_W'(n_points);
        return o;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        outcome_t want;
        if (!rst_n)
        begin
            n_points   = 0;
            range_lo   = RANGE_LO_RST;
            range_hi   = RANGE_HI_RST;
            merge_dist = HIT_DIST_RST;
            outcome_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unrequested result: expected none actual status %0d",
                             $time, status);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", longint'(want.status), longint'(status));
                    check_field("occupied", longint'(want.occupied), longint'(occupied));
                    check_field("entry_index", longint'(want.index), longint'(entry_index));
                    check_field("entry_weight", longint'(want.weight),
                                longint'(entry_weight));
                    check_field("stored_count", longint'(want.count),
                                longint'(stored_count));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RANGE_LO: range_lo   = cfg_data;
                    CFG_RANGE_HI: range_hi   = cfg_data;
                    CFG_HIT_DIST: merge_dist = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                outcome_q.push_back(cluster_request(cmd, pos_x, pos_y, range_mm, query_dist_mm));
            outstanding = outcome_q.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
    import hpct_pkg::*;

    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int DRAIN_CYCLES  = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      cmd = CMD_INSERT;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic [DIST_W-1:0]         range_mm = '0;
    logic [DIST_W-1:0]         query_dist_mm = '0;
    logic                      done;
    logic [STATUS_W-1:0]       status;
    logic                      occupied;
    logic [IDX_W-1:0]          entry_index;
    logic [WEIGHT_W-1:0]       entry_weight;
    logic [CNT_W-1:0]          stored_count;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = CFG_RANGE_LO;
    logic [DIST_W-1:0]         cfg_data = '0;

    int errors;
    int pending;
    int cycle_count = 0;

    int cur_min = int'(RANGE_LO_RST);
    int cur_max = int'(RANGE_HI_RST);
    int cur_hit = int'(HIT_DIST_RST);

    hit_point_cluster_table_top u_dut (.*);
    hpct_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int to_coord(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int window_range();
        if (cur_max > cur_min)
            return $urandom_range(cur_min + 1, cur_max);
        return $urandom_range(0, 65535);
    endfunction

    function automatic int rand16();
        return $urandom_range(0, 65535);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic void near_point(input int ox, input int oy, input int spread,
                                       output int px, output int py);
        px = to_coord(ox + int'($urandom_range(0, 2 * spread)) - spread);
        py = to_coord(oy + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // start stays high after the request is taken; pause or wait_results lowers it
    task automatic send_req(input logic c, input int x, input int y, input int rng, input int qd);
        start         <= 1'b1;
        cmd           <= c;
        pos_x         <= COORD_W'(x);
        pos_y         <= COORD_W'(y);
        range_mm      <= DIST_W'(rng);
        query_dist_mm <= DIST_W'(qd);
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIST_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_config(input int lo, input int hi, input int md);
        wait_results();
        cfg_put(CFG_UNUSED, rand16());
        cfg_put(CFG_RANGE_LO, lo);
        cfg_put(CFG_RANGE_HI, hi);
        cfg_put(CFG_HIT_DIST, md);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cur_min = lo;
        cur_max = hi;
        cur_hit = md;
    endtask

    initial
    begin
        int p;
        int k;
        int c;
        int n_items;
        int roll;
        int spread;
        int px;
        int py;
        int rng;
        int lo;
        int hi;
        int md;
        bit idle_on;
        int cx [8];
        int cy [8];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: window (200, 8000], merge radius 200
        send_req(CMD_QUERY, 0, 0, 0, 65535);
        send_req(CMD_INSERT, 0, 0, 200, 0);
        send_req(CMD_INSERT, 0, 0, 8001, 0);
        send_req(CMD_INSERT, 0, 0, 201, 0);
        send_req(CMD_INSERT, 199, 0, 8000, 0);
        send_req(CMD_INSERT, 200, 0, 8000, 0);
        send_req(CMD_INSERT, 100, 0, 5000, 0);
        send_req(CMD_INSERT, 0, 0, 0, 0);
        send_req(CMD_INSERT, 0, 0, 65535, 65535);
        send_req(CMD_INSERT, -32768, -32768, 1000, 0);
        send_req(CMD_INSERT, 32767, 32767, 1000, 0);
        send_req(CMD_QUERY, 0, 0, 0, 0);
        send_req(CMD_QUERY, 300, 0, 0, 101);
        send_req(CMD_QUERY, 300, 0, 65535, 100);
        send_req(CMD_QUERY, -32768, 32767, 0, 65535);
        set_config(0, 65535, 65535);
        send_req(CMD_INSERT, 0, 0, 0, 0);
        send_req(CMD_INSERT, 32767, -32768, 65535, 0);
        set_config(0, 65535, 0);
        send_req(CMD_INSERT, 0, 0, 1, 0);
        send_req(CMD_INSERT, 0, 0, 1, 0);
        set_config(65535, 65535, 200);
        send_req(CMD_INSERT, 5, 5, 65535, 0);
        set_config(0, 0, 200);
        send_req(CMD_INSERT, 5, 5, 0, 0);
        send_req(CMD_INSERT, 5, 5, 1, 0);

        for (p = 0; p < 10; p++)
        begin
            case (p)
                0:       begin lo = 200;   hi = 8000;  md = 200;   n_items = 70; end
                1:       begin lo = 0;     hi = 65535; md = 1000;  n_items = 70; end
                2:       begin lo = 1000;  hi = 3000;  md = 1500;  n_items = 60; end
                3:       begin lo = 0;     hi = 65535; md = 65535; n_items = 60; end
                4:       begin lo = 65535; hi = 65535; md = 300;   n_items = 15; end
                5:       begin lo = 0;     hi = 0;     md = 300;   n_items = 15; end
                6:       begin lo = 100;   hi = 9000;  md = 0;     n_items = 20; end
                default:
                begin
                    lo = $urandom_range(0, 3000);
                    hi = $urandom_range(lo, 20000);
                    md = $urandom_range(50, 5000);
                    n_items = 80;
                end
            endcase
            set_config(lo, hi, md);
            for (k = 0; k < 8; k++)
            begin
                cx[k] = int'($urandom_range(0, 50000)) - 25000;
                cy[k] = int'($urandom_range(0, 50000)) - 25000;
            end
            spread  = (cur_hit == 0) ? 300 : ((cur_hit > 6000) ? 2000 : cur_hit / 3);
            // no idling in phases 1, 4 and 7, nor in the last phase
            idle_on = (p % 3 != 1) && (p != 9);
            for (k = 0; k < n_items; k++)
            begin
                if (idle_on && $urandom_range(0, 3) == 0)
                    pause($urandom_range(1, 19));
                roll = $urandom_range(0, 99);
                c = $urandom_range(0, 7);
                near_point(cx[c], cy[c], spread, px, py);
                if (roll < 45)
                    send_req(CMD_INSERT, px, py, window_range(), rand16());
                else if (roll < 53)
                    send_req(CMD_INSERT, rand_coord(), rand_coord(), window_range(), rand16());
                else if (roll < 68)
                    send_req(CMD_QUERY, px, py, rand16(), $urandom_range(0, 3 * spread + 100));
                else if (roll < 78)
                    send_req(CMD_QUERY, rand_coord(), rand_coord(), rand16(), rand16());
                else if (roll < 90)
                begin
                    if (cur_min > 0 && (cur_max == 65535 || $urandom_range(0, 1) == 0))
                        rng = $urandom_range(0, cur_min);
                    else if (cur_max < 65535)
                        rng = $urandom_range(cur_max + 1, 65535);
                    else
                        rng = 0;
                    send_req(CMD_INSERT, px, py, rng, rand16());
                end
                else
                    send_req(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand16(),
                             rand16());
            end
        end

        // zero merge radius, then full merge radius
        set_config(0, 65535, 0);
        send_req(CMD_INSERT, rand_coord(), rand_coord(), window_range(), 0);
        send_req(CMD_INSERT, 0, 0, 65535, 0);
        send_req(CMD_INSERT, -32768, 32767, 1, 0);
        send_req(CMD_INSERT, 0, 0, 0, 0);
        send_req(CMD_QUERY, 0, 0, 0, 0);
        send_req(CMD_QUERY, 0, 0, 0, 65535);
        set_config(0, 65535, 65535);
        send_req(CMD_INSERT, 10, -10, 500, 0);
        send_req(CMD_QUERY, 32767, 32767, 65535, 1);

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
